>>> design/ignition_angle_timer_converter_defines.svh
// Assertion macros for the ignition angle timer converter.
// Used by the top level; expects clk_i and rst_ni in scope.
`ifndef IGNITION_ANGLE_TIMER_CONVERTER_DEFINES_SVH
`define IGNITION_ANGLE_TIMER_CONVERTER_DEFINES_SVH

`define IATC_CHECK(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`define IATC_ALWAYS(name, cond, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) \
    else $error(msg);

`endif

>>> design/iatc_pkg.sv
// Shared types and constants for the ignition angle timer converter.
// No dependencies.
package iatc_pkg;

  localparam int unsigned NumW   = 47;
  localparam int unsigned DivW   = 30;
  localparam int unsigned QuoW   = 24;
  localparam int unsigned CntW   = 19;
  localparam int unsigned SatShift = 14;

  localparam logic [1:0] CFG_PICKUP = 2'd0;
  localparam logic [1:0] CFG_TUNE   = 2'd1;
  localparam logic [1:0] CFG_CPDM   = 2'd2;

  localparam logic [29:0] CPDM_RESET = 30'd666666667;
  localparam logic [19:0] MICRO      = 20'd1000000;
  localparam logic [23:0] TEN_MICRO  = 24'd10000000;
  localparam logic [31:0] RECIP_TEN  = 32'hCCCCCCCD;

  localparam logic signed [15:0] ANGLE_MAX = 16'sd3600;
  localparam logic signed [15:0] ANGLE_MIN = -16'sd3600;

  typedef enum logic {
    OP_ENCODE = 1'b0,
    OP_DECODE = 1'b1
  } op_e;

  typedef struct packed {
    op_e  op;
    logic kill;
    logic sat;
  } side_t;

endpackage

>>> design/iatc_front.sv
// Front end: operand preparation for the shared divider, five stages.
// Depends on iatc_pkg.
module iatc_front import iatc_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 vld_i,
  input  logic                 op_i,
  input  logic signed [12:0]   angle_i,
  input  logic [15:0]          word_i,
  input  logic [7:0]           speed_i,
  input  logic [11:0]          pickup_i,
  input  logic [15:0]          tune_i,
  input  logic [29:0]          cpdm_i,
  output logic                 vld_o,
  output side_t                side_o,
  output logic [NumW-1:0]      num_o,
  output logic [DivW-1:0]      den_o
);

  logic signed [13:0] tenths;
  logic               tpos;
  logic [42:0]        num_enc;
  logic [27:0]        den_enc;
  logic [4:0]         post;
  logic [12:0]        pp;
  logic [CntW-1:0]    cnt;
  side_t              side1_d;

  logic               vld1_q, vld2_q, vld3_q, vld4_q, vld5_q;
  side_t              side1_q, side2_q, side3_q, side4_q, side5_q;
  logic [42:0]        num1_q, num2_q, num3_q, num4_q;
  logic [27:0]        den1_q, den2_q, den3_q, den4_q;
  logic [CntW-1:0]    cnt1_q;
  logic [7:0]         spd1_q;
  logic [26:0]        v2_q;
  logic [58:0]        m3_q;
  logic [NumW-1:0]    x4_q;
  logic [NumW-1:0]    num5_q;
  logic [DivW-1:0]    den5_q;

  logic [DivW-1:0]    cpdm_eff;
  logic               sat5;
  side_t              side5_d;

  always_comb begin
    tenths  = $signed({2'b00, pickup_i}) - $signed({angle_i[12], angle_i});
    tpos    = !tenths[13] && (tenths != 14'sd0);
    num_enc = tpos ? 43'(tenths[12:0]) * 43'(cpdm_i) : 43'd0;
    den_enc = 28'(speed_i) * 28'(MICRO);
    post    = {1'b0, word_i[14:11]} + 5'd1;
    pp      = 13'(word_i[7:0]) * 13'(post);
    cnt     = (CntW'(pp) << {word_i[9:8], 1'b0}) + CntW'(tune_i);
    side1_d.op   = op_e'(op_i);
    side1_d.kill = op_i ? (word_i == 16'd0) : ((angle_i == 13'sd0) || (speed_i == 8'd0));
    side1_d.sat  = 1'b0;
  end

  always_comb begin
    cpdm_eff = (cpdm_i == '0) ? DivW'(1) : cpdm_i;
    sat5     = (side4_q.op == OP_DECODE) && (x4_q >= NumW'({cpdm_eff, 14'd0}));
    side5_d      = side4_q;
    side5_d.sat  = sat5;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld1_q <= 1'b0;
      vld2_q <= 1'b0;
      vld3_q <= 1'b0;
      vld4_q <= 1'b0;
      vld5_q <= 1'b0;
    end else begin
      vld1_q <= vld_i;
      vld2_q <= vld1_q;
      vld3_q <= vld2_q;
      vld4_q <= vld3_q;
      vld5_q <= vld4_q;
    end
  end

  always_ff @(posedge clk_i) begin
    side1_q <= side1_d;
    num1_q  <= num_enc;
    den1_q  <= den_enc;
    cnt1_q  <= cnt;
    spd1_q  <= speed_i;

    side2_q <= side1_q;
    num2_q  <= num1_q;
    den2_q  <= den1_q;
    v2_q    <= 27'(cnt1_q) * 27'(spd1_q);

    side3_q <= side2_q;
    num3_q  <= num2_q;
    den3_q  <= den2_q;
    m3_q    <= 59'(v2_q) * 59'(RECIP_TEN);

    side4_q <= side3_q;
    num4_q  <= num3_q;
    den4_q  <= den3_q;
    x4_q    <= NumW'(m3_q[57:35]) * NumW'(TEN_MICRO);

    side5_q <= side5_d;
    if (side4_q.op == OP_DECODE) begin
      num5_q <= sat5 ? '0 : x4_q;
      den5_q <= cpdm_eff;
    end else begin
      num5_q <= NumW'(num4_q);
      den5_q <= DivW'(den4_q);
    end
  end

  assign vld_o  = vld5_q;
  assign side_o = side5_q;
  assign num_o  = num5_q;
  assign den_o  = den5_q;

endmodule

>>> design/iatc_div.sv
// Restoring divider, one quotient bit per stage.
// Depends on iatc_pkg.
module iatc_div import iatc_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             vld_i,
  input  side_t            side_i,
  input  logic [NumW-1:0]  num_i,
  input  logic [DivW-1:0]  den_i,
  output logic             vld_o,
  output side_t            side_o,
  output logic [QuoW-1:0]  quo_o,
  output logic [NumW-1:0]  rem_o
);

  localparam int unsigned WideW = DivW + QuoW;

  logic [QuoW-1:0] vld_q;
  side_t           side_q [QuoW];
  logic [NumW-1:0] rem_q  [QuoW];
  logic [DivW-1:0] den_q  [QuoW];
  logic [QuoW-1:0] quo_q  [QuoW];

  for (genvar k = 0; k < QuoW; k++) begin : g_stage
    localparam int unsigned Bit = QuoW - 1 - k;
    logic             vld_in;
    side_t            side_in;
    logic [NumW-1:0]  rem_in;
    logic [DivW-1:0]  den_in;
    logic [QuoW-1:0]  quo_in;
    logic [WideW-1:0] shifted;
    logic             ge;
    logic [NumW-1:0]  rem_d;
    logic [QuoW-1:0]  quo_d;

    if (k == 0) begin : g_first
      assign vld_in  = vld_i;
      assign side_in = side_i;
      assign rem_in  = num_i;
      assign den_in  = den_i;
      assign quo_in  = '0;
    end else begin : g_next
      assign vld_in  = vld_q[k-1];
      assign side_in = side_q[k-1];
      assign rem_in  = rem_q[k-1];
      assign den_in  = den_q[k-1];
      assign quo_in  = quo_q[k-1];
    end

    always_comb begin
      shifted = WideW'(den_in) << Bit;
      ge      = WideW'(rem_in) >= shifted;
      rem_d   = ge ? NumW'(WideW'(rem_in) - shifted) : rem_in;
      quo_d      = quo_in;
      quo_d[Bit] = ge;
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else begin
        vld_q[k] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      side_q[k] <= side_in;
      rem_q[k]  <= rem_d;
      den_q[k]  <= den_in;
      quo_q[k]  <= quo_d;
    end
  end

  assign vld_o  = vld_q[QuoW-1];
  assign side_o = side_q[QuoW-1];
  assign quo_o  = quo_q[QuoW-1];
  assign rem_o  = rem_q[QuoW-1];

endmodule

>>> design/iatc_back.sv
// Back end: prescale selection, period division, angle saturation, outputs.
// Depends on iatc_pkg.
module iatc_back import iatc_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                vld_i,
  input  side_t               side_i,
  input  logic [QuoW-1:0]     quo_i,
  input  logic [NumW-1:0]     rem_i,
  input  logic [11:0]         pickup_i,
  input  logic [15:0]         tune_i,
  output logic                valid_o,
  output logic [15:0]         word_o,
  output logic signed [12:0]  angle_o,
  output logic                ovf_o
);

  function automatic logic [15:0] per_step(input logic [11:0] rem, input logic [4:0] div,
                                           input logic hi);
    logic [11:0] r;
    logic [3:0]  qb;
    logic [12:0] sh;
    r  = rem;
    qb = '0;
    for (int j = 3; j >= 0; j--) begin
      sh = 13'(div) << (hi ? j + 4 : j);
      if ({1'b0, r} >= sh) begin
        r     = 12'({1'b0, r} - sh);
        qb[j] = 1'b1;
      end
    end
    return {r, qb};
  endfunction

  logic [QuoW-1:0]    c2;
  logic [15:0]        h;
  logic [1:0]         code;
  logic               ovf;
  logic [15:0]        hs;
  logic [QuoW-1:0]    cs;
  logic [13:0]        q14;
  logic               less;
  logic signed [15:0] diff;
  logic signed [15:0] ang;

  logic               vld1_q, vld2_q, vld3_q;
  side_t              side1_q, side2_q;
  logic               ovf1_q, ovf2_q;
  logic [1:0]         code1_q, code2_q;
  logic [4:0]         post1_q, post2_q;
  logic [11:0]        cnt1_q, rem2_q;
  logic [12:0]        ang1_q, ang2_q;
  logic [3:0]         qhi2_q;
  logic [15:0]        st2, st3;
  logic [4:0]         pm1;
  logic [15:0]        word_q;
  logic [12:0]        angle_q;
  logic               ovf_q;

  always_comb begin
    c2   = (quo_i > QuoW'(tune_i)) ? quo_i - QuoW'(tune_i) : '0;
    h    = c2[23:8];
    ovf  = 1'b0;
    if (h < 16'd16) begin
      code = 2'd0;
    end else if (h < 16'd64) begin
      code = 2'd1;
    end else if (h < 16'd256) begin
      code = 2'd2;
    end else if (h < 16'd1024) begin
      code = 2'd3;
    end else begin
      code = 2'd3;
      ovf  = 1'b1;
    end
    hs   = h >> {code, 1'b0};
    cs   = c2 >> {code, 1'b0};

    q14  = quo_i[13:0];
    less = {2'b00, q14} < {4'd0, pickup_i};
    diff = $signed({4'd0, pickup_i}) - $signed({2'b00, q14})
         - ((less && (rem_i[DivW-1:0] != '0)) ? 16'sd1 : 16'sd0);
    if (side_i.sat || diff < ANGLE_MIN) begin
      ang = ANGLE_MIN;
    end else if (diff > ANGLE_MAX) begin
      ang = ANGLE_MAX;
    end else begin
      ang = diff;
    end
  end

  assign st2 = per_step(cnt1_q, post1_q, 1'b1);
  assign st3 = per_step(rem2_q, post2_q, 1'b0);
  assign pm1 = post2_q - 5'd1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld1_q <= 1'b0;
      vld2_q <= 1'b0;
      vld3_q <= 1'b0;
    end else begin
      vld1_q <= vld_i;
      vld2_q <= vld1_q;
      vld3_q <= vld2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    side1_q <= side_i;
    ovf1_q  <= ovf;
    code1_q <= code;
    post1_q <= {1'b0, hs[3:0]} + 5'd1;
    cnt1_q  <= cs[11:0];
    ang1_q  <= ang[12:0];

    side2_q <= side1_q;
    ovf2_q  <= ovf1_q;
    code2_q <= code1_q;
    post2_q <= post1_q;
    rem2_q  <= st2[15:4];
    qhi2_q  <= st2[3:0];
    ang2_q  <= ang1_q;

    if (side2_q.kill || side2_q.op == OP_DECODE || ovf2_q) begin
      word_q <= '0;
    end else begin
      word_q <= {1'b0, pm1[3:0], 1'b1, code2_q, qhi2_q, st3[3:0]};
    end
    angle_q <= (side2_q.op == OP_DECODE && !side2_q.kill) ? ang2_q : '0;
    ovf_q   <= (side2_q.op == OP_ENCODE) && !side2_q.kill && ovf2_q;
  end

  assign valid_o = vld3_q;
  assign word_o  = word_q;
  assign angle_o = $signed(angle_q);
  assign ovf_o   = ovf_q;

endmodule

>>> design/ignition_angle_timer_converter.sv
// Pipeline from start_i to valid_o: 5 front, 24 divider and 3 back stages.
// Throughput: one transaction per cycle; busy_o stays low, the receiver cannot stall.
// Each result stands on the outputs for one cycle, marked by valid_o.
// Reset clears the valid bits and loads the configuration registers with defaults.
// Depends on iatc_pkg, iatc_front, iatc_div, iatc_back and the defines header.
`include "ignition_angle_timer_converter_defines.svh"

module ignition_angle_timer_converter import iatc_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  output logic               busy_o,
  input  logic               op_i,
  input  logic signed [12:0] angle_tenths_i,
  input  logic [15:0]        timer_word_in_i,
  input  logic [7:0]         speed_index_i,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_idx_i,
  input  logic [29:0]        cfg_wdata_i,
  output logic               valid_o,
  output logic [15:0]        timer_word_out_o,
  output logic signed [12:0] angle_out_tenths_o,
  output logic               overflow_o
);

  logic [11:0]     pickup_q;
  logic [15:0]     tune_q;
  logic [29:0]     cpdm_q;

  logic            f_vld;
  side_t           f_side;
  logic [NumW-1:0] f_num;
  logic [DivW-1:0] f_den;
  logic            d_vld;
  side_t           d_side;
  logic [QuoW-1:0] d_quo;
  logic [NumW-1:0] d_rem;

  assign busy_o = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pickup_q <= '0;
      tune_q   <= '0;
      cpdm_q   <= CPDM_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_PICKUP: pickup_q <= cfg_wdata_i[11:0];
        CFG_TUNE:   tune_q   <= cfg_wdata_i[15:0];
        CFG_CPDM:   cpdm_q   <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  iatc_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .vld_i    (start_i && !busy_o),
    .op_i     (op_i),
    .angle_i  (angle_tenths_i),
    .word_i   (timer_word_in_i),
    .speed_i  (speed_index_i),
    .pickup_i (pickup_q),
    .tune_i   (tune_q),
    .cpdm_i   (cpdm_q),
    .vld_o    (f_vld),
    .side_o   (f_side),
    .num_o    (f_num),
    .den_o    (f_den)
  );

  iatc_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .vld_i  (f_vld),
    .side_i (f_side),
    .num_i  (f_num),
    .den_i  (f_den),
    .vld_o  (d_vld),
    .side_o (d_side),
    .quo_o  (d_quo),
    .rem_o  (d_rem)
  );

  iatc_back u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .vld_i    (d_vld),
    .side_i   (d_side),
    .quo_i    (d_quo),
    .rem_i    (d_rem),
    .pickup_i (pickup_q),
    .tune_i   (tune_q),
    .valid_o  (valid_o),
    .word_o   (timer_word_out_o),
    .angle_o  (angle_out_tenths_o),
    .ovf_o    (overflow_o)
  );

  `IATC_CHECK(a_ovf_zero_word, valid_o && overflow_o, timer_word_out_o == 16'd0 && angle_out_tenths_o == 13'sd0, "overflow with nonzero result")
  `IATC_CHECK(a_word_enable, valid_o && timer_word_out_o != 16'd0, timer_word_out_o[10] && !timer_word_out_o[15] && angle_out_tenths_o == 13'sd0, "malformed timer word")
  `IATC_ALWAYS(a_angle_range, !valid_o || (angle_out_tenths_o <= 13'sd3600 && angle_out_tenths_o >= -13'sd3600), "angle out of range")

endmodule

>>> bench/ignition_angle_timer_converter_tb.sv
// Testbench for ignition_angle_timer_converter: directed and random encode/decode
// transactions over several register settings, checked against an in-bench predictor.
// Depends on iatc_pkg and the converter RTL.
`timescale 1ns / 1ps

module ignition_angle_timer_converter_tb;
  import iatc_pkg::*;

  typedef longint unsigned u64_t;

  typedef struct {
    op_e               op;
    logic signed [12:0] angle;
    logic [15:0]        word;
    logic [7:0]         speed;
  } conv_req_t;

  typedef struct {
    logic [15:0]        word;
    logic signed [12:0] angle;
    logic               ovf;
  } conv_res_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               start_i = 1'b0;
  logic               busy_o;
  logic               op_i = 1'b0;
  logic signed [12:0] angle_tenths_i = '0;
  logic [15:0]        timer_word_in_i = '0;
  logic [7:0]         speed_index_i = '0;
  logic               cfg_we_i = 1'b0;
  logic [1:0]         cfg_idx_i = CFG_PICKUP;
  logic [29:0]        cfg_wdata_i = '0;
  logic               valid_o;
  logic [15:0]        timer_word_out_o;
  logic signed [12:0] angle_out_tenths_o;
  logic               overflow_o;

  ignition_angle_timer_converter dut (.*);

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  logic [11:0] pickup_q = '0;
  logic [15:0] tune_q = '0;
  logic [29:0] cpdm_q = CPDM_RESET;

  conv_req_t pending_q[$];
  conv_res_t expected_q[$];
  int        errors = 0;
  int        n_encode = 0;
  int        n_decode = 0;
  int        n_overflow = 0;
  int        n_settings = 1;
  int        idle_cycles = 0;
  int        gap = 0;

  function automatic conv_res_t predict_conversion(op_e op, logic signed [12:0] ang,
                                                   logic [15:0] w, logic [7:0] spd);
    conv_res_t         r;
    longint            tenths;
    longint unsigned   count;
    longint unsigned   h;
    longint unsigned   p;
    longint unsigned   post;
    longint unsigned   period;
    longint unsigned   code;
    longint            dcount;
    longint            q;
    longint            c;
    longint            quo;
    r.word = '0;
    r.angle = '0;
    r.ovf = 1'b0;
    if (op == OP_ENCODE) begin
      if (ang != 0 && spd != 0) begin
        tenths = longint'(pickup_q) - longint'(ang);
        count = 0;
        if (tenths > 0)
          count = (u64_t'(tenths) * cpdm_q) / (u64_t'(spd) * 1000000);
        count = (count > tune_q) ? count - tune_q : 0;
        h = count >> 8;
        if (h < 16) begin p = 1; code = 0; end
        else if (h < 64) begin p = 4; code = 1; end
        else if (h < 256) begin p = 16; code = 2; end
        else if (h < 1024) begin p = 64; code = 3; end
        else begin
          r.ovf = 1'b1;
          return r;
        end
        post = h / p + 1;
        period = count / (p * post);
        r.word = 16'(((post - 1) << 11) | (1 << 10) | (code << 8) | (period & 8'hff));
      end
    end else if (w != 0) begin
      dcount = (longint'(1) << (2 * w[9:8])) * longint'(w[7:0]) * (longint'(w[14:11]) + 1)
               + longint'(tune_q);
      q = (dcount * longint'(spd)) / 10;
      c = (cpdm_q != 0) ? longint'(cpdm_q) : 1;
      quo = (longint'(pickup_q) * c - q * 10000000) / c;
      if (quo > 3600) quo = 3600;
      if (quo < -3600) quo = -3600;
      r.angle = 13'(quo);
    end
    return r;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    errors++;
    $display("result %0d: %s got %0d expected %0d", n_encode + n_decode, what, got, want);
  endtask

  // driver
  always @(posedge clk_i) begin
    if (start_i && !busy_o) begin
      expected_q.push_back(predict_conversion(op_e'(op_i), angle_tenths_i,
                                              timer_word_in_i, speed_index_i));
    end
    if (!(start_i && busy_o)) begin
      if (gap > 0) begin
        gap--;
        start_i <= 1'b0;
      end else if (pending_q.size() > 0) begin
        conv_req_t t;
        t = pending_q.pop_front();
        op_i <= t.op;
        angle_tenths_i <= t.angle;
        timer_word_in_i <= t.word;
        speed_index_i <= t.speed;
        start_i <= 1'b1;
        case ($urandom_range(0, 19))
          0:       gap = $urandom_range(10, 60);
          1, 2, 3: gap = $urandom_range(1, 4);
          default: gap = 0;
        endcase
      end else begin
        start_i <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk_i) begin
    if (rst_ni && valid_o) begin
      if (expected_q.size() == 0) begin
        report_mismatch("unexpected transaction", 0, 0);
      end else begin
        conv_res_t e;
        e = expected_q.pop_front();
        if (timer_word_out_o !== e.word)
          report_mismatch("timer_word_out", timer_word_out_o, e.word);
        if (angle_out_tenths_o !== e.angle)
          report_mismatch("angle_out_tenths", angle_out_tenths_o, e.angle);
        if (overflow_o !== e.ovf)
          report_mismatch("overflow", overflow_o, e.ovf);
        if (e.ovf) n_overflow++;
        if (e.word != 0 || e.ovf || timer_word_out_o != 0) n_encode++;
        else n_decode++;
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    if ((start_i && !busy_o) || valid_o) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 5000) begin
      $display("ignition_angle_timer_converter: mismatch");
      $finish;
    end
  end

  task automatic add_item(op_e op, int ang, int w, int spd);
    conv_req_t t;
    t.op = op;
    t.angle = 13'(ang);
    t.word = 16'(w);
    t.speed = 8'(spd);
    pending_q.push_back(t);
  endtask

  task automatic add_random_item();
    int kind;
    kind = $urandom_range(0, 9);
    if (kind == 0) begin
      add_item(op_e'($urandom_range(0, 1)), $urandom_range(0, 8191),
               $urandom_range(0, 65535), $urandom_range(0, 255));
    end else if (kind < 6) begin
      add_item(OP_ENCODE, int'($urandom_range(0, 7200)) - 3600, $urandom_range(0, 65535),
               $urandom_range(0, 159));
    end else begin
      add_item(OP_DECODE, $urandom_range(0, 8191),
               ($urandom_range(0, 15) << 11) | (1 << 10) | ($urandom_range(0, 3) << 8)
               | $urandom_range(0, 255), $urandom_range(0, 159));
    end
  endtask

  task automatic write_reg(logic [1:0] idx, logic [29:0] data);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= data;
    case (idx)
      CFG_PICKUP: pickup_q = data[11:0];
      CFG_TUNE:   tune_q = data[15:0];
      CFG_CPDM:   cpdm_q = data;
      default: ;
    endcase
  endtask

  task automatic drain();
    while (pending_q.size() > 0 || expected_q.size() > 0 || start_i)
      @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  task automatic new_setting(int pk, int tn, int cp, int items);
    drain();
    write_reg(CFG_PICKUP, 30'(pk));
    write_reg(CFG_TUNE, 30'(tn));
    write_reg(CFG_CPDM, 30'(cp));
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    n_settings++;
    repeat (items) add_random_item();
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    add_item(OP_ENCODE, 0, 0, 100);
    add_item(OP_ENCODE, -300, 0, 0);
    add_item(OP_ENCODE, -3600, 0, 1);
    add_item(OP_ENCODE, -3600, 0, 159);
    add_item(OP_ENCODE, 3600, 0, 50);
    add_item(OP_ENCODE, -4096, 65535, 255);
    add_item(OP_ENCODE, 4095, 0, 255);
    add_item(OP_ENCODE, -1, 0, 159);
    add_item(OP_ENCODE, -200, 0, 80);
    add_item(OP_DECODE, 0, 0, 100);
    add_item(OP_DECODE, 0, 65535, 255);
    add_item(OP_DECODE, 4095, 1, 159);
    add_item(OP_DECODE, 0, 16'h0400, 1);
    add_item(OP_DECODE, 0, 16'h7fff, 0);
    add_item(OP_DECODE, 0, 16'h87ff, 10);
    add_item(OP_DECODE, -4096, 16'h0500, 255);
    repeat (300) add_random_item();
    new_setting(3600, 0, 1000000000, 150);
    new_setting(4095, 65535, 30'h3fffffff, 150);
    new_setting(0, 300, 1, 100);
    new_setting(1800, 0, 0, 100);
    new_setting($urandom_range(0, 3600), $urandom_range(0, 2000),
                $urandom_range(100000000, 1000000000), 200);
    new_setting(3600, $urandom_range(0, 65535), 666666667, 200);
    drain();
    $display("covered %0d register settings, %0d results checked (%0d overflows)",
             n_settings, n_encode + n_decode, n_overflow);
    if (errors == 0) begin
      $display("ignition_angle_timer_converter: match");
    end else begin
      $display("ignition_angle_timer_converter: mismatch");
    end
    $finish;
  end

endmodule

>>> ignition_angle_timer_converter.f
+incdir+design
design/iatc_pkg.sv
design/iatc_front.sv
design/iatc_div.sv
design/iatc_back.sv
design/ignition_angle_timer_converter.sv
bench/ignition_angle_timer_converter_tb.sv
